FILE: sv/pfa_pkg.sv
`default_nettype none
package pfa_pkg;
   localparam int NUM_PAGES  = 1024;
   localparam int PAGE_SHIFT = 12;
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int LINK_W     = PAGE_W + 1;
   localparam int ADDR_W     = 23;
   localparam int FLAG_W     = 6;
   localparam int WORD_W     = FLAG_W + 2;
   localparam int EPAGE_W    = ADDR_W - PAGE_SHIFT + 1;

   localparam logic [LINK_W-1:0] NO_PAGE = LINK_W'(NUM_PAGES);
   localparam logic [ADDR_W:0]   PAGE_ROUND = (ADDR_W+1)'((1 << PAGE_SHIFT) - 1);

   localparam int FLAG_USED = 0;
   localparam int FLAG_FREE = 1;
   localparam int FLAG_PHYS = 2;
   localparam int FLAG_VIRT = 3;

   typedef enum logic [1:0] {
      ACT_MARK  = 2'd0,
      ACT_ALLOC = 2'd1,
      ACT_FREE  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_BAD     = 2'd1,
      STS_NO_FREE = 2'd2,
      STS_PAST    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_TOTAL = 2'd0,
      REG_FIRST = 2'd1,
      REG_COUNT = 2'd2,
      REG_SPARE = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [LINK_W-1:0] total_pages;
      logic [PAGE_W-1:0] table_first_page;
      logic [LINK_W-1:0] table_page_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] granted_page;
      logic [LINK_W-1:0] free_count;
      logic [LINK_W-1:0] used_count;
   } res_type;

   function automatic logic in_table(cfg_type cfg, logic [PAGE_W-1:0] pg);
      logic [PAGE_W-1:0] diff;
      diff = pg - cfg.table_first_page;
      return (pg >= cfg.table_first_page) && ({1'b0, diff} < cfg.table_page_count);
   endfunction

   function automatic logic [LINK_W-1:0] pages_present(cfg_type cfg);
      return (cfg.total_pages > NO_PAGE) ? NO_PAGE : cfg.total_pages;
   endfunction
endpackage
`default_nettype wire

FILE: sv/page_frame_allocator.sv
`default_nettype none
// Channel   Direction  Handshake          Carries
// req_      in         valid / stall      action, addresses, flags, page index
// rsp_      out        valid / stall      status, granted page, free and used counts
// csr_      in         APB style          total_pages, table_first_page, table_page_count
//
// Steps: allocate reads, evaluates, finishes; free also makes two append writes;
// a mark range reads and evaluates each page walked, appending a page put on the
// free list; a rejected item or empty range finishes at once. Each page reads the
// page word and link memories once, then writes them (none for a protected page).
// Reset: the page word memory is swept to zero, one entry a cycle, over all 1024
// entries after reset; no item is taken meanwhile, configuration writes are.
// Stalls: the result waits in an output register, so the next item is taken
// while an earlier result is held against rsp_stall.
module page_frame_allocator (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_action,
   input  wire logic [pfa_pkg::ADDR_W-1:0]   req_start_address,
   input  wire logic [pfa_pkg::ADDR_W-1:0]   req_end_address,
   input  wire logic [pfa_pkg::FLAG_W-1:0]   req_mark_flags,
   input  wire logic [pfa_pkg::PAGE_W-1:0]   req_page_index,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [pfa_pkg::PAGE_W-1:0]        rsp_granted_page,
   output logic [pfa_pkg::LINK_W-1:0]        rsp_free_count,
   output logic [pfa_pkg::LINK_W-1:0]        rsp_used_count,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [3:0]                   csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic      [31:0]                  csr_prdata,
   output logic                              csr_pready
);
   import pfa_pkg::*;

   cfg_type cfg;
   res_type res, rsp_ff;
   logic    done, slot_free, rsp_valid_ff;

   pfa_csr u_csr (
      .clock(clock), .reset(reset),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready), .cfg(cfg));

   pfa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .cfg(cfg),
      .req_valid(req_valid), .req_stall(req_stall), .req_action(req_action),
      .req_start_address(req_start_address), .req_end_address(req_end_address),
      .req_mark_flags(req_mark_flags), .req_page_index(req_page_index),
      .slot_free(slot_free), .done(done), .res(res));

   // the slot frees when empty or when its item leaves at this edge
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      // hold the payload until a new item lands
      if (done) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_ff.status;
   assign rsp_granted_page = rsp_ff.granted_page;
   assign rsp_free_count   = rsp_ff.free_count;
   assign rsp_used_count   = rsp_ff.used_count;
endmodule
`default_nettype wire

FILE: sv/pfa_ram.sv
`default_nettype none
module pfa_ram #(
   parameter int WIDTH = 8,
   parameter int AW    = 10
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: sv/pfa_csr.sv
`default_nettype none
module pfa_csr (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic      [31:0]  csr_prdata,
   output logic              csr_pready,
   output pfa_pkg::cfg_type  cfg
);
   import pfa_pkg::*;

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type idx;

   assign idx        = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_pages      <= NO_PAGE;
         cfg_ff.table_first_page <= '0;
         cfg_ff.table_page_count <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_TOTAL: cfg_ff.total_pages      <= csr_pwdata[LINK_W-1:0];
            REG_FIRST: cfg_ff.table_first_page <= csr_pwdata[PAGE_W-1:0];
            REG_COUNT: cfg_ff.table_page_count <= csr_pwdata[LINK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_TOTAL: csr_prdata = 32'(cfg_ff.total_pages);
         REG_FIRST: csr_prdata = 32'(cfg_ff.table_first_page);
         REG_COUNT: csr_prdata = 32'(cfg_ff.table_page_count);
         default:   csr_prdata = '0;
      endcase
   end
endmodule
`default_nettype wire

FILE: sv/pfa_ctrl.sv
`default_nettype none
module pfa_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pfa_pkg::cfg_type             cfg,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_action,
   input  wire logic [pfa_pkg::ADDR_W-1:0]   req_start_address,
   input  wire logic [pfa_pkg::ADDR_W-1:0]   req_end_address,
   input  wire logic [pfa_pkg::FLAG_W-1:0]   req_mark_flags,
   input  wire logic [pfa_pkg::PAGE_W-1:0]   req_page_index,
   input  wire logic                         slot_free,
   output logic                              done,
   output pfa_pkg::res_type                  res
);
   import pfa_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_READ   = 7'b0000100,
      ST_EVAL   = 7'b0001000,
      ST_APP1   = 7'b0010000,
      ST_APP2   = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [PAGE_W-1:0]  cur_ff, cur_in;
   logic [PAGE_W-1:0]  clr_ff, clr_in;
   logic [EPAGE_W-1:0] end_ff, end_in;
   action_type         act_ff, act_in;
   logic [FLAG_W-1:0]  flags_ff, flags_in;
   status_type         status_ff, status_in;
   logic [PAGE_W-1:0]  granted_ff, granted_in;
   logic [LINK_W-1:0]  head_ff, head_in, tail_ff, tail_in;
   logic [LINK_W-1:0]  free_total_ff, free_total_in, used_total_ff, used_total_in;

   logic               pw_we, nx_we, pv_we, rd_en;
   logic [PAGE_W-1:0]  pw_wa, nx_wa, pv_wa;
   logic [WORD_W-1:0]  pw_wd, pw_rd;
   logic [LINK_W-1:0]  nx_wd, pv_wd, nx_rd, pv_rd;

   logic [ADDR_W:0]     end_round;
   logic [EPAGE_W-1:0]  s_page, e_page, cur_next;
   logic [1:0]          sel;
   logic [FLAG_W-1:0]   w_flags;
   logic                w_onf, w_used, prot, new_used, do_app, is_mark;

   assign rd_en = (state_ff == ST_READ);

   pfa_ram #(.WIDTH(WORD_W), .AW(PAGE_W)) u_page (
      .clock(clock), .wr_en(pw_we), .wr_addr(pw_wa), .wr_data(pw_wd),
      .rd_en(rd_en), .rd_addr(cur_ff), .rd_data(pw_rd));
   pfa_ram #(.WIDTH(LINK_W), .AW(PAGE_W)) u_next (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_en(rd_en), .rd_addr(cur_ff), .rd_data(nx_rd));
   pfa_ram #(.WIDTH(LINK_W), .AW(PAGE_W)) u_prev (
      .clock(clock), .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
      .rd_en(rd_en), .rd_addr(cur_ff), .rd_data(pv_rd));

   assign end_round = {1'b0, req_end_address} + PAGE_ROUND;
   assign s_page    = EPAGE_W'(req_start_address >> PAGE_SHIFT);
   assign e_page    = end_round[ADDR_W:PAGE_SHIFT];
   assign sel       = {req_mark_flags[FLAG_FREE], req_mark_flags[FLAG_USED]};
   assign cur_next  = EPAGE_W'(cur_ff) + EPAGE_W'(1);

   assign w_flags  = pw_rd[WORD_W-1:2];
   assign w_onf    = pw_rd[1];
   assign w_used   = pw_rd[0];
   assign is_mark  = (act_ff == ACT_MARK);
   assign prot     = w_flags[FLAG_PHYS] || w_flags[FLAG_VIRT] || in_table(cfg, cur_ff);
   assign new_used = is_mark ? flags_ff[FLAG_USED] : (act_ff == ACT_ALLOC);
   assign do_app   = is_mark ? flags_ff[FLAG_FREE] : (act_ff == ACT_FREE);

   assign req_stall = (state_ff != ST_IDLE);
   assign done      = (state_ff == ST_FINISH) && slot_free;
   assign res       = '{status: status_ff, granted_page: granted_ff,
                        free_count: free_total_ff, used_count: used_total_ff};

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      clr_in        = clr_ff;
      end_in        = end_ff;
      act_in        = act_ff;
      flags_in      = flags_ff;
      status_in     = status_ff;
      granted_in    = granted_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_total_in = free_total_ff;
      used_total_in = used_total_ff;
      pw_we = 1'b0; pw_wa = cur_ff; pw_wd = '0;
      nx_we = 1'b0; nx_wa = cur_ff; nx_wd = NO_PAGE;
      pv_we = 1'b0; pv_wa = cur_ff; pv_wd = NO_PAGE;

      case (state_ff)
         ST_CLEAR: begin
            pw_we  = 1'b1;
            pw_wa  = clr_ff;
            clr_in = clr_ff + PAGE_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               act_in     = action_type'(req_action);
               flags_in   = req_mark_flags;
               granted_in = '0;
               status_in  = STS_OK;
               state_in   = ST_FINISH;
               case (action_type'(req_action))
                  ACT_MARK: begin
                     if (req_start_address > req_end_address || sel == 2'b11
                         || sel == 2'b00) begin
                        status_in = STS_BAD;
                     end else if (e_page > EPAGE_W'(pages_present(cfg))) begin
                        status_in = STS_PAST;
                     end else if (s_page != e_page) begin
                        cur_in   = s_page[PAGE_W-1:0];
                        end_in   = e_page;
                        state_in = ST_READ;
                     end
                  end
                  ACT_ALLOC: begin
                     if (head_ff == NO_PAGE) begin
                        status_in = STS_NO_FREE;
                     end else begin
                        cur_in     = head_ff[PAGE_W-1:0];
                        granted_in = head_ff[PAGE_W-1:0];
                        state_in   = ST_READ;
                     end
                  end
                  ACT_FREE: begin
                     if ({1'b0, req_page_index} >= pages_present(cfg)
                         || in_table(cfg, req_page_index)) begin
                        status_in = STS_BAD;
                     end else begin
                        cur_in   = req_page_index;
                        state_in = ST_READ;
                     end
                  end
                  default: status_in = STS_BAD;
               endcase
            end
         end
         ST_READ: state_in = ST_EVAL;
         ST_EVAL: begin
            if (!(is_mark && prot)) begin
               pw_we = 1'b1;
               pw_wd = {(is_mark ? flags_ff : w_flags), do_app, new_used};
               used_total_in = used_total_ff + LINK_W'(new_used) - LINK_W'(w_used);
               if (w_onf) begin
                  free_total_in = free_total_ff - LINK_W'(1);
                  if (pv_rd != NO_PAGE) begin
                     nx_we = 1'b1; nx_wa = pv_rd[PAGE_W-1:0]; nx_wd = nx_rd;
                  end else begin
                     head_in = nx_rd;
                  end
                  if (nx_rd != NO_PAGE) begin
                     pv_we = 1'b1; pv_wa = nx_rd[PAGE_W-1:0]; pv_wd = pv_rd;
                  end else begin
                     tail_in = pv_rd;
                  end
               end
            end
            if (!(is_mark && prot) && do_app) begin
               state_in = ST_APP1;
            end else if (is_mark && cur_next < end_ff) begin
               cur_in   = cur_next[PAGE_W-1:0];
               state_in = ST_READ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_APP1: begin
            pv_we = 1'b1;
            pv_wd = tail_ff;
            if (tail_ff != NO_PAGE) begin
               nx_we = 1'b1; nx_wa = tail_ff[PAGE_W-1:0]; nx_wd = {1'b0, cur_ff};
            end else begin
               head_in = {1'b0, cur_ff};
            end
            state_in = ST_APP2;
         end
         ST_APP2: begin
            nx_we         = 1'b1;
            tail_in       = {1'b0, cur_ff};
            free_total_in = free_total_ff + LINK_W'(1);
            if (is_mark && cur_next < end_ff) begin
               cur_in   = cur_next[PAGE_W-1:0];
               state_in = ST_READ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         head_ff       <= NO_PAGE;
         tail_ff       <= NO_PAGE;
         free_total_ff <= '0;
         used_total_ff <= '0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_total_ff <= free_total_in;
         used_total_ff <= used_total_in;
      end
      cur_ff     <= cur_in;
      end_ff     <= end_in;
      act_ff     <= act_in;
      flags_ff   <= flags_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   a_list_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> ((head_ff == NO_PAGE) == (tail_ff == NO_PAGE)))
      else $error("free list head and tail disagree on emptiness");
   a_list_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> ((free_total_ff == '0) == (head_ff == NO_PAGE)))
      else $error("free count disagrees with list head");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      free_total_ff <= NO_PAGE && used_total_ff <= NO_PAGE)
      else $error("page count beyond page total");
   a_no_write_in_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> !(pw_we || nx_we || pv_we))
      else $error("memory write in the read cycle");
endmodule
`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none
module tb_top;
   import pfa_pkg::*;

   typedef struct {
      logic [1:0]        act;
      logic [ADDR_W-1:0] sa;
      logic [ADDR_W-1:0] ea;
      logic [FLAG_W-1:0] fl;
      logic [PAGE_W-1:0] pi;
   } page_req_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_action = ACT_NONE;
   logic [ADDR_W-1:0] req_start_address = '0;
   logic [ADDR_W-1:0] req_end_address = '0;
   logic [FLAG_W-1:0] req_mark_flags = '0;
   logic [PAGE_W-1:0] req_page_index = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_status;
   logic [PAGE_W-1:0] rsp_granted_page;
   logic [LINK_W-1:0] rsp_free_count;
   logic [LINK_W-1:0] rsp_used_count;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [3:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   page_frame_allocator u_top (.*);

   // 12 unit period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow of the allocator: page flags, free list links, membership, counts
   logic [FLAG_W-1:0] shadow_flags[NUM_PAGES] = '{default: '0};
   int                next_link[NUM_PAGES];
   int                prev_link[NUM_PAGES];
   bit                listed[NUM_PAGES];
   bit                taken[NUM_PAGES];
   int                list_head = NUM_PAGES;
   int                list_tail = NUM_PAGES;
   int                n_free = 0;
   int                n_used = 0;
   int                total_pages = 1024;
   int                window_first = 0;
   int                window_count = 0;

   page_req_t         pending_items[$];
   res_type           awaited_results[$];
   int                mismatches = 0;
   int                items_sent = 0;
   int                results_seen = 0;
   int                status_seen[4] = '{default: 0};
   bit                quiet = 1'b0;

   function automatic int present();
      return (total_pages > NUM_PAGES) ? NUM_PAGES : total_pages;
   endfunction

   function automatic bit in_window(int pg);
      return pg >= window_first && (pg - window_first) < window_count;
   endfunction

   function automatic void unlink(int pg);
      int nx, pv;
      if (!listed[pg]) return;
      nx = next_link[pg];
      pv = prev_link[pg];
      if (pv < NUM_PAGES) next_link[pv] = nx; else list_head = nx;
      if (nx < NUM_PAGES) prev_link[nx] = pv; else list_tail = pv;
      listed[pg] = 1'b0;
      n_free--;
   endfunction

   function automatic void push_tail(int pg);
      unlink(pg);
      next_link[pg] = NUM_PAGES;
      prev_link[pg] = list_tail;
      if (list_tail < NUM_PAGES) next_link[list_tail] = pg; else list_head = pg;
      list_tail = pg;
      listed[pg] = 1'b1;
      n_free++;
   endfunction

   function automatic void mark_taken(int pg, bit u);
      if (taken[pg] && !u) n_used--;
      if (!taken[pg] && u) n_used++;
      taken[pg] = u;
   endfunction

   function automatic status_type walk_range(page_req_t r);
      int s, e;
      if (r.sa > r.ea) return STS_BAD;
      if (r.fl[FLAG_USED] == r.fl[FLAG_FREE]) return STS_BAD;
      s = int'(r.sa) >> PAGE_SHIFT;
      e = (int'(r.ea) + (1 << PAGE_SHIFT) - 1) >> PAGE_SHIFT;
      if (e > present()) return STS_PAST;
      for (; s < e; s++) begin
         if (shadow_flags[s][FLAG_PHYS] || shadow_flags[s][FLAG_VIRT] || in_window(s))
            continue;
         shadow_flags[s] = r.fl;
         if (r.fl[FLAG_USED]) begin
            unlink(s);
            mark_taken(s, 1'b1);
         end else begin
            mark_taken(s, 1'b0);
            push_tail(s);
         end
      end
      return STS_OK;
   endfunction

   // work out the result that one accepted item produces
   function automatic res_type predict_result(page_req_t r);
      res_type    res;
      status_type st;
      int         pg;
      st = STS_BAD;
      res.granted_page = '0;
      case (r.act)
         ACT_MARK: st = walk_range(r);
         ACT_ALLOC: begin
            if (list_head >= NUM_PAGES) st = STS_NO_FREE;
            else begin
               pg = list_head;
               unlink(pg);
               mark_taken(pg, 1'b1);
               res.granted_page = PAGE_W'(pg);
               st = STS_OK;
            end
         end
         ACT_FREE: begin
            pg = int'(r.pi);
            if (pg < present() && !in_window(pg)) begin
               mark_taken(pg, 1'b0);
               push_tail(pg);
               st = STS_OK;
            end
         end
         default: st = STS_BAD;
      endcase
      res.status = st;
      res.free_count = LINK_W'(n_free);
      res.used_count = LINK_W'(n_used);
      return res;
   endfunction

   task automatic report(input string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
   endtask

   function automatic void queue_item(logic [1:0] act, int sa, int ea, int fl, int pi);
      page_req_t r;
      r.act = act;
      r.sa = ADDR_W'(sa);
      r.ea = ADDR_W'(ea);
      r.fl = FLAG_W'(fl);
      r.pi = PAGE_W'(pi);
      pending_items.push_back(r);
   endfunction

   // mostly well-formed traffic: small marks, allocations and releases,
   // with a little noise and the odd whole-memory walk
   function automatic void queue_random(int n);
      int k, pick, sa, lim, fl;
      lim = present();
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) queue_item(ACT_ALLOC, $urandom, $urandom, $urandom, $urandom);
         else if (pick < 55)
            queue_item(ACT_FREE, $urandom, $urandom, $urandom,
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                   : $urandom_range(0, lim - 1));
         else if (pick < 86) begin
            sa = $urandom_range(0, lim - 1) * 4096 + $urandom_range(0, 4095);
            fl = $urandom_range(0, 15) << 2;
            // keep most pages unprotected so the list stays busy
            if ($urandom_range(0, 7) != 0) fl = fl & 6'h33;
            fl = fl | ($urandom_range(0, 2) == 0 ? 1 : 2);
            queue_item(ACT_MARK, sa, sa + $urandom_range(0, 8 * 4096), fl, $urandom);
         end else if (pick < 87)
            queue_item(ACT_MARK, 0, lim * 4096, 2, $urandom);
         else
            queue_item($urandom_range(0, 3), $urandom_range(0, 8388607),
                       $urandom_range(0, 8388607), $urandom_range(0, 63),
                       $urandom_range(0, 1023));
      end
   endfunction

   // accept the item in flight, then advance, idle or hold
   int gap_left = 0;
   always @(posedge clock) begin
      page_req_t cur, nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            cur.act = req_action;
            cur.sa = req_start_address;
            cur.ea = req_end_address;
            cur.fl = req_mark_flags;
            cur.pi = req_page_index;
            awaited_results.push_back(predict_result(cur));
            items_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left <= gap_left - 1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
               req_valid <= 1'b0;
               gap_left <= $urandom_range(0, 3);
            end else if (pending_items.size() > 0) begin
               nxt = pending_items.pop_front();
               req_action <= nxt.act;
               req_start_address <= nxt.sa;
               req_end_address <= nxt.ea;
               req_mark_flags <= nxt.fl;
               req_page_index <= nxt.pi;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver back-pressure: random bursts, plus one long hold-off so the
   // block backs up onto its input
   int  stall_left = 0;
   int  hold_left = 0;
   bit  held_once = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!held_once && results_seen >= 300) begin
         rsp_stall <= 1'b1;
         held_once <= 1'b1;
         hold_left <= 400;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         status_seen[rsp_status]++;
         if (awaited_results.size() == 0) begin
            report("result with no item outstanding");
         end else begin
            want = awaited_results.pop_front();
            if (rsp_status !== want.status)
               report($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_granted_page !== want.granted_page)
               report($sformatf("granted page %0d, want %0d",
                                rsp_granted_page, want.granted_page));
            if (rsp_free_count !== want.free_count)
               report($sformatf("free count %0d, want %0d",
                                rsp_free_count, want.free_count));
            if (rsp_used_count !== want.used_count)
               report($sformatf("used count %0d, want %0d",
                                rsp_used_count, want.used_count));
         end
      end
   end

   // register write: setup cycle, then access cycle
   task automatic write_reg(input reg_index_type idx, input int value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_TOTAL: total_pages = value & 32'h7FF;
         REG_FIRST: window_first = value & 32'h3FF;
         REG_COUNT: window_count = value & 32'h7FF;
         default: ;
      endcase
   endtask

   task automatic set_window(input int tot, input int first, input int cnt);
      write_reg(REG_TOTAL, tot);
      write_reg(REG_FIRST, first);
      write_reg(REG_COUNT, cnt);
   endtask

   // drain: nothing queued, nothing in flight, then a short settle
   task automatic drain();
      do @(negedge clock);
      while (pending_items.size() != 0 || awaited_results.size() != 0 || req_valid);
      repeat (16) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      set_window(1024, 4, 2);

      // directed: empty list, range checks, protection, re-marking, odd actions
      queue_item(ACT_ALLOC, 0, 0, 0, 0);
      queue_item(ACT_MARK, 0, 10 * 4096 - 1, 2, 0);
      queue_item(ACT_MARK, 4194304, 4194304, 2, 0);
      queue_item(ACT_MARK, 8192, 4096, 2, 0);
      queue_item(ACT_MARK, 0, 4096, 3, 0);
      queue_item(ACT_MARK, 0, 4096, 0, 0);
      queue_item(ACT_MARK, 0, 4096, 63, 0);
      queue_item(ACT_MARK, 0, 4194305, 2, 0);
      queue_item(ACT_MARK, 0, 8388607, 1, 0);
      queue_item(ACT_ALLOC, 0, 0, 0, 0);
      queue_item(ACT_ALLOC, 0, 0, 0, 0);
      queue_item(ACT_FREE, 0, 0, 0, 1023);
      queue_item(ACT_FREE, 0, 0, 0, 4);
      queue_item(ACT_FREE, 0, 0, 0, 0);
      queue_item(ACT_FREE, 0, 0, 0, 0);
      queue_item(ACT_MARK, 8 * 4096, 10 * 4096, 6'h3D, 0);
      queue_item(ACT_MARK, 0, 12 * 4096, 2, 0);
      queue_item(ACT_MARK, 4096, 8192, 2, 0);
      queue_item(ACT_MARK, 2 * 4096 + 5, 3 * 4096 + 1, 1, 0);
      queue_item(ACT_MARK, 2 * 4096, 3 * 4096, 1, 0);
      queue_item(ACT_NONE, 8388607, 8388607, 63, 1023);
      queue_item(ACT_FREE, 0, 0, 0, 9);
      queue_item(ACT_ALLOC, 0, 0, 0, 0);
      drain();

      set_window(1023, 1023, 1023);
      queue_random(300);
      drain();
      set_window(1, 0, 0);
      queue_random(120);
      drain();
      set_window(600, 100, 50);
      queue_random(400);
      drain();
      set_window(1024, 0, 1024);
      queue_random(80);
      drain();
      set_window(1024, 300, 20);
      queue_random(350);
      // final stretch runs flat out on both sides
      do @(negedge clock);
      while (pending_items.size() != 0);
      quiet = 1'b1;
      queue_random(280);
      drain();
      repeat (40) @(posedge clock);

      $display("Covered %0d items over six table/size settings, one long receiver hold.",
               items_sent);
      $display("Status ok %0d, bad %0d, no free %0d, past memory %0d.",
               status_seen[STS_OK], status_seen[STS_BAD], status_seen[STS_NO_FREE],
               status_seen[STS_PAST]);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("page_frame_allocator: match");
      end else begin
         $display("page_frame_allocator: mismatch");
      end
      $finish;
   end

   // give up well beyond the slowest correct run
   initial begin
      #(12 * 3000000);
      $display("TIMEOUT with %0d results outstanding", awaited_results.size());
      $display("page_frame_allocator: mismatch");
      $finish;
   end
endmodule
`default_nettype wire
